// ===== rtl/pmiw_pkg.sv =====
`timescale 1ns / 1ps

package pmiw_pkg;

  localparam int CoordWidth = 32;
  localparam int EntryWidth = 21;
  localparam int CoordFrac  = 12;
  localparam int LatFrac    = EntryWidth - 9;
  localparam int InvFrac    = EntryWidth - 3;
  localparam int FracBits   = CoordFrac + InvFrac;
  localparam int OutShift   = LatFrac + InvFrac;
  localparam int RegWidth   = 63;
  localparam int CfgIdxW    = 3;

  localparam int ProdW    = EntryWidth + CoordWidth;
  localparam int FracSumW = ProdW + 2;
  localparam int RemW     = FracBits + 1;
  localparam int LProdW   = EntryWidth + RemW;
  localparam int OutSumW  = LProdW + 2;
  localparam int RndW     = OutSumW + 1;
  localparam int ShiftW   = RndW - OutShift;
  localparam int CmpW     = (ShiftW > CoordWidth) ? ShiftW + 1 : CoordWidth + 1;

  typedef logic signed [EntryWidth-1:0] entry_t;
  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [ProdW-1:0]      prod_t;
  typedef logic signed [RemW-1:0]       rem_t;
  typedef logic signed [LProdW-1:0]     lprod_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLatRow0 = 3'd0,
    CfgLatRow1 = 3'd1,
    CfgLatRow2 = 3'd2,
    CfgInvRow0 = 3'd3,
    CfgInvRow1 = 3'd4,
    CfgInvRow2 = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    ReqMinImage = 1'b0,
    ReqWrap     = 1'b1
  } req_type_e;

endpackage

// ===== rtl/periodic_minimum_image_wrap_top.sv =====
// Throughput: one vector per cycle while the output accepts, through the two pairs
// of multiply and sum stages: fraction products, remainders, lattice products, outputs.
// Each stage holds its item under backpressure, so a stall loses or repeats nothing.
// Reset clears all pipeline valid bits and loads identity lattice and inverse matrices.
`timescale 1ns / 1ps

module periodic_minimum_image_wrap_top import pmiw_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [RegWidth-1:0]     cfg_data_i,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // vec_x, vec_y, vec_z
  input  logic [3*CoordWidth-1:0] s_axis_tdata,
  // req_type
  input  logic                    s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // out_x, out_y, out_z
  output logic [3*CoordWidth-1:0] m_axis_tdata,
  // saturated
  output logic                    m_axis_tuser
);

  entry_t lat [3][3];
  entry_t inv [3][3];
  coord_t vec [3];
  rem_t   rem [3];
  coord_t res [3];
  logic   rem_vld, rem_rdy;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vec[k] = coord_t'(s_axis_tdata[CoordWidth*k +: CoordWidth]);
    end
  end

  pmiw_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .lat_o       (lat),
    .inv_o       (inv)
  );

  pmiw_frac u_frac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s_axis_tvalid),
    .ready_o    (s_axis_tready),
    .req_type_i (s_axis_tuser),
    .vec_i      (vec),
    .inv_i      (inv),
    .valid_o    (rem_vld),
    .ready_i    (rem_rdy),
    .rem_o      (rem)
  );

  pmiw_cart u_cart (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rem_vld),
    .ready_o (rem_rdy),
    .rem_i   (rem),
    .lat_i   (lat),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .out_o   (res),
    .sat_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {res[2], res[1], res[0]};

endmodule

// ===== rtl/pmiw_cfg.sv =====
`timescale 1ns / 1ps

module pmiw_cfg import pmiw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [RegWidth-1:0] cfg_data_i,
  output entry_t              lat_o [3][3],
  output entry_t              inv_o [3][3]
);

  entry_t lat_q [3][3];
  entry_t inv_q [3][3];
  entry_t wr_row [3];

  assign cfg_ready_o = 1'b1;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      wr_row[j] = entry_t'(cfg_data_i[EntryWidth*j +: EntryWidth]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          lat_q[i][j] <= (i == j) ? entry_t'(1 << LatFrac) : '0;
          inv_q[i][j] <= (i == j) ? entry_t'(1 << InvFrac) : '0;
        end
      end
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgLatRow0: lat_q[0] <= wr_row;
        CfgLatRow1: lat_q[1] <= wr_row;
        CfgLatRow2: lat_q[2] <= wr_row;
        CfgInvRow0: inv_q[0] <= wr_row;
        CfgInvRow1: inv_q[1] <= wr_row;
        CfgInvRow2: inv_q[2] <= wr_row;
        default: ;
      endcase
    end
  end

  assign lat_o = lat_q;
  assign inv_o = inv_q;

endmodule

// ===== rtl/pmiw_frac.sv =====
`timescale 1ns / 1ps

module pmiw_frac import pmiw_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  logic   req_type_i,
  input  coord_t vec_i [3],
  input  entry_t inv_i [3][3],
  output logic   valid_o,
  input  logic   ready_i,
  output rem_t   rem_o [3]
);

  logic  prod_vld_q, rem_vld_q;
  logic  prod_rdy, rem_rdy;
  logic  mode_q;
  prod_t prod_q [3][3];
  rem_t  rem_q [3];
  rem_t  rem_d [3];

  assign rem_rdy  = !rem_vld_q || ready_i;
  assign prod_rdy = !prod_vld_q || rem_rdy;
  assign ready_o  = prod_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      rem_vld_q  <= 1'b0;
    end else begin
      if (prod_rdy) prod_vld_q <= valid_i;
      if (rem_rdy)  rem_vld_q  <= prod_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_rdy && valid_i) begin
      mode_q <= req_type_i;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[i][j] <= ProdW'(inv_i[i][j]) * ProdW'(vec_i[j]);
        end
      end
    end
  end

  always_comb begin
    logic signed [FracSumW-1:0] sum;
    logic [FracBits-1:0]        r;
    logic [FracBits-1:0]        half;
    logic                       top;
    half = {1'b1, {(FracBits-1){1'b0}}};
    for (int i = 0; i < 3; i++) begin
      sum = FracSumW'(prod_q[i][0]) + FracSumW'(prod_q[i][1]) + FracSumW'(prod_q[i][2]);
      r   = sum[FracBits-1:0];
      top = (req_type_e'(mode_q) == ReqMinImage) &&
            ((r > half) || ((r == half) && !sum[FracSumW-1]));
      rem_d[i] = rem_t'({top, r});
    end
  end

  always_ff @(posedge clk_i) begin
    if (rem_rdy && prod_vld_q) begin
      rem_q <= rem_d;
    end
  end

  assign valid_o = rem_vld_q;
  assign rem_o   = rem_q;

endmodule

// ===== rtl/pmiw_cart.sv =====
`timescale 1ns / 1ps

module pmiw_cart import pmiw_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  rem_t   rem_i [3],
  input  entry_t lat_i [3][3],
  output logic   valid_o,
  input  logic   ready_i,
  output coord_t out_o [3],
  output logic   sat_o
);

  logic   prod_vld_q, out_vld_q;
  logic   prod_rdy, out_rdy;
  lprod_t prod_q [3][3];
  coord_t out_q [3];
  coord_t out_d [3];
  logic   sat_q, sat_d;

  assign out_rdy  = !out_vld_q || ready_i;
  assign prod_rdy = !prod_vld_q || out_rdy;
  assign ready_o  = prod_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (prod_rdy) prod_vld_q <= valid_i;
      if (out_rdy)  out_vld_q  <= prod_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_rdy && valid_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[i][j] <= LProdW'(lat_i[i][j]) * LProdW'(rem_i[j]);
        end
      end
    end
  end

  always_comb begin
    logic signed [RndW-1:0]   sum;
    logic signed [RndW-1:0]   bias;
    logic signed [RndW-1:0]   rnd;
    logic signed [ShiftW-1:0] shr;
    logic signed [CmpW-1:0]   val;
    logic signed [CmpW-1:0]   max_v;
    logic signed [CmpW-1:0]   min_v;
    max_v = CmpW'({1'b0, {(CoordWidth-1){1'b1}}});
    min_v = CmpW'($signed({1'b1, {(CoordWidth-1){1'b0}}}));
    sat_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sum  = RndW'(prod_q[i][0]) + RndW'(prod_q[i][1]) + RndW'(prod_q[i][2]);
      bias = sum[RndW-1] ? RndW'((1 << (OutShift-1)) - 1) : RndW'(1 << (OutShift-1));
      rnd  = sum + bias;
      shr  = rnd[RndW-1:OutShift];
      val  = CmpW'(shr);
      if (val > max_v) begin
        val   = max_v;
        sat_d = 1'b1;
      end else if (val < min_v) begin
        val   = min_v;
        sat_d = 1'b1;
      end
      out_d[i] = val[CoordWidth-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && prod_vld_q) begin
      out_q <= out_d;
      sat_q <= sat_d;
    end
  end

  assign valid_o = out_vld_q;
  assign out_o   = out_q;
  assign sat_o   = sat_q;

endmodule
